// ===== sv/double_ended_queue_macros.svh =====
// Assertion macros shared by the double-ended queue RTL.
// No dependencies; files that assert include it by name.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Asserts a property at every rising clock edge outside reset.
`define DEQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("double-ended queue assertion failed");

// Asserts that a condition never holds outside reset.
`define DEQ_NEVER(label, clk, rst, cond) \
   `DEQ_ASSERT(label, clk, rst, !(cond))

`endif

// ===== sv/deq_pkg.sv =====
// Types and constants of the double-ended queue.
// No dependencies; used by every module of the block but deq_ram.
`default_nettype none

package deq_pkg;

   localparam int VALUE_W     = 32;
   localparam int OCC_W       = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic               is_push;
      logic               at_front;
      logic [VALUE_W-1:0] value;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } link_type;

endpackage

`default_nettype wire

// ===== sv/deq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/deq_front.sv =====
// Front part: accepts request items, classifies them and holds them in a
// short queue for the back part. Depends on deq_pkg.
`default_nettype none

module deq_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_kind,
   input  wire logic signed [deq_pkg::VALUE_W-1:0] req_push_value,
   output deq_pkg::link_type                link,
   input  wire logic                        link_pop
);

   import deq_pkg::*;

   localparam int QP_W = $clog2(QUEUE_DEPTH);
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   op_type           entry_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  fill_ff, fill_in;
   logic             accept;
   logic             take;
   op_type           classified;

   always_comb begin
      classified.value = $unsigned(req_push_value);
      case (kind_type'(req_kind))
         KIND_PUSH_FRONT: begin
            classified.is_push  = 1'b1;
            classified.at_front = 1'b1;
         end
         KIND_PUSH_BACK: begin
            classified.is_push  = 1'b1;
            classified.at_front = 1'b0;
         end
         KIND_POP_FRONT: begin
            classified.is_push  = 1'b0;
            classified.at_front = 1'b1;
         end
         default: begin
            classified.is_push  = 1'b0;
            classified.at_front = 1'b0;
         end
      endcase
   end

   assign req_stall = (fill_ff == QC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign take      = link_pop && (fill_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         fill_in = fill_ff + 1'b1;
      end else if (take && !accept) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

   assign link.valid = (fill_ff != '0);
   assign link.op    = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== sv/deq_back.sv =====
// Back part: carries out queued operations on the ring buffer and holds
// the result item. Depends on deq_pkg, deq_ram and the assertion macros.
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_back #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire deq_pkg::link_type                  link,
   output logic                                    link_pop,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_status,
   output logic signed [deq_pkg::VALUE_W-1:0]      rsp_pop_value,
   output logic [deq_pkg::OCC_W-1:0]               rsp_occupancy
);

   import deq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       front_ff, front_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   status_type             status_ff, status_in;
   logic [VALUE_W-1:0]     pop_value_ff, pop_value_in;
   logic [CNT_W-1:0]       offset;
   logic [IDX_W:0]         ring_sum;
   logic [IDX_W-1:0]       back_idx;
   logic [IDX_W-1:0]       front_dec;
   logic [IDX_W-1:0]       front_inc;
   logic                   is_full;
   logic                   is_empty;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [WORD_WIDTH-1:0]  rd_data;

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign offset    = link.op.is_push ? count_ff : count_ff - 1'b1;
   assign front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

   always_comb begin
      ring_sum = (IDX_W + 1)'(front_ff) + (IDX_W + 1)'(offset);
      if (ring_sum >= (IDX_W + 1)'(DEPTH)) begin
         ring_sum = ring_sum - (IDX_W + 1)'(DEPTH);
      end
      back_idx = ring_sum[IDX_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      pop_value_in = pop_value_ff;
      link_pop     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = link.op.at_front ? front_dec : back_idx;
      rd_en        = 1'b0;
      rd_addr      = link.op.at_front ? front_ff : back_idx;
      case (state_ff)
         ST_IDLE: begin
            if (link.valid) begin
               link_pop     = 1'b1;
               pop_value_in = '0;
               status_in    = STATUS_DONE;
               if (link.op.is_push) begin
                  state_in = ST_SEND;
                  if (is_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (link.op.at_front) begin
                        front_in = front_dec;
                     end
                  end
               end else if (is_empty) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_SEND;
               end else begin
                  rd_en    = 1'b1;
                  count_in = count_ff - 1'b1;
                  state_in = ST_READ;
                  if (link.op.at_front) begin
                     front_in = front_inc;
                  end
               end
            end
         end
         ST_READ: begin
            pop_value_in = VALUE_W'(rd_data);
            state_in     = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      pop_value_ff <= pop_value_in;
   end

   deq_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (WORD_WIDTH'(link.op.value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = (state_ff == ST_SEND);
   assign rsp_status    = status_ff;
   assign rsp_pop_value = $signed(pop_value_ff);
   assign rsp_occupancy = OCC_W'(count_ff);

   `DEQ_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH))
   `DEQ_ASSERT(a_full_report, clock, reset,
      (rsp_valid && status_ff == STATUS_FULL) |-> is_full && pop_value_ff == '0)
   `DEQ_ASSERT(a_empty_report, clock, reset,
      (rsp_valid && status_ff == STATUS_EMPTY) |-> is_empty && pop_value_ff == '0)
   `DEQ_ASSERT(a_write_source, clock, reset,
      wr_en |-> (state_ff == ST_IDLE && link.valid && link.op.is_push && !is_full))
   `DEQ_ASSERT(a_count_step, clock, reset,
      ##1 (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1
           || count_ff == $past(count_ff) - 1'b1))

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue on a ring buffer.
// Depends on deq_pkg, deq_front, deq_back (and through it deq_ram).
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid / req_stall  req_kind, req_push_value
//   rsp       out         rsp_valid / rsp_stall  rsp_status, rsp_pop_value,
//                                                rsp_occupancy
//
// A push or a refused operation goes from ST_IDLE to ST_SEND in the back
// sequencer; a successful pop passes through ST_READ between the two, for the
// registered read of the slot RAM. The two-entry input queue registers each
// item and keeps taking items until full while a result waits on rsp_stall.
// Synchronous reset empties the ring and the queue; slot contents are not cleared.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_kind,
   input  wire logic signed [deq_pkg::VALUE_W-1:0] req_push_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [1:0]                              rsp_status,
   output logic signed [deq_pkg::VALUE_W-1:0]      rsp_pop_value,
   output logic [deq_pkg::OCC_W-1:0]               rsp_occupancy
);

   import deq_pkg::*;

   link_type link;
   logic     link_pop;

   deq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .link           (link),
      .link_pop       (link_pop)
   );

   deq_back #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .link          (link),
      .link_pop      (link_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_pop_value (rsp_pop_value),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the double-ended queue on a ring buffer.
// Depends on deq_pkg and double_ended_queue; a directed table is followed by random items.
`timescale 1ns / 100ps

module testbench;
   import deq_pkg::*;

   localparam int RING_SIZE   = 16;
   localparam int ITEM_COUNT  = 1950;
   localparam int PLAN_ROWS   = 24;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 12;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] value;
      logic [OCC_W-1:0]   occ;
   } deque_result_type;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] word;
      logic               typed;
      deque_result_type   result;
   } plan_row_type;

   localparam plan_row_type PLAN [0:PLAN_ROWS-1] = '{
      '{KIND_POP_FRONT,  32'h0000_0000, 1'b1, '{STATUS_EMPTY, 32'h0, 5'd0}},
      '{KIND_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{STATUS_EMPTY, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h8000_0000, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'h0000_0000, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_POP_BACK,   32'h1234_5678, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_POP_FRONT,  32'h0000_0000, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h5555_5555, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h0000_0001, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h3333_3333, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'hCCCC_CCCC, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h00FF_00FF, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'hFF00_FF00, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h8000_0001, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'h7FFF_FFFE, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_BACK,  32'h0BAD_F00D, 1'b0, '{STATUS_DONE, 32'h0, 5'd0}},
      '{KIND_PUSH_FRONT, 32'h1111_1111, 1'b1, '{STATUS_FULL, 32'h0, 5'd16}},
      '{KIND_PUSH_BACK,  32'h2222_2222, 1'b1, '{STATUS_FULL, 32'h0, 5'd16}}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   kind_type                  req_kind;
   logic signed [VALUE_W-1:0] req_push_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic signed [VALUE_W-1:0] rsp_pop_value;
   logic [OCC_W-1:0]          rsp_occupancy;

   logic                      item_typed;
   deque_result_type          item_result;

   logic [VALUE_W-1:0]        ring_words [0:RING_SIZE-1];
   int                        ring_front = 0;
   int                        ring_count = 0;
   deque_result_type          awaited_results [$];

   int                        error_count = 0;
   int                        idle_cycles = 0;
   int                        stall_mode = 0;
   int                        stall_left = 0;

   double_ended_queue #(
      .DEPTH      (RING_SIZE),
      .WORD_WIDTH (VALUE_W)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_occupancy  (rsp_occupancy)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic deque_result_type deque_apply(kind_type kind,
                                                    logic [VALUE_W-1:0] word);
      deque_result_type r;
      r.status = STATUS_DONE;
      r.value  = '0;
      case (kind)
         KIND_PUSH_FRONT: begin
            if (ring_count == RING_SIZE) begin
               r.status = STATUS_FULL;
            end else begin
               ring_front = (ring_front == 0) ? RING_SIZE - 1 : ring_front - 1;
               ring_words[ring_front] = word;
               ring_count++;
            end
         end
         KIND_PUSH_BACK: begin
            if (ring_count == RING_SIZE) begin
               r.status = STATUS_FULL;
            end else begin
               ring_words[(ring_front + ring_count) % RING_SIZE] = word;
               ring_count++;
            end
         end
         KIND_POP_FRONT: begin
            if (ring_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.value = ring_words[ring_front];
               ring_front = (ring_front + 1) % RING_SIZE;
               ring_count--;
            end
         end
         default: begin
            if (ring_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.value = ring_words[(ring_front + ring_count - 1) % RING_SIZE];
               ring_count--;
            end
         end
      endcase
      r.occ = ring_count[OCC_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [VALUE_W-1:0] got,
                                  logic [VALUE_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      error_count++;
   endtask

   task automatic send_item(kind_type kind, logic [VALUE_W-1:0] word, logic typed,
                            deque_result_type result);
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_push_value <= word;
      item_typed     <= typed;
      item_result    <= result;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      deque_result_type predicted;
      deque_result_type oldest;
      idle_cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (awaited_results.size() == 0) begin
               $display("%0t: result with no item outstanding", $realtime);
               error_count++;
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch("status", VALUE_W'(rsp_status), VALUE_W'(oldest.status));
               if (rsp_pop_value !== oldest.value)
                  report_mismatch("pop value", rsp_pop_value, oldest.value);
               if (rsp_occupancy !== oldest.occ)
                  report_mismatch("occupancy", VALUE_W'(rsp_occupancy), VALUE_W'(oldest.occ));
            end
         end
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            predicted = deque_apply(req_kind, req_push_value);
            awaited_results.push_back(item_typed ? item_result : predicted);
         end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(8, 48);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 99) < 35);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   initial begin
      kind_type           kind;
      logic [VALUE_W-1:0] word;
      int                 burst_left;
      int                 phase_left;
      int                 push_percent;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_PUSH_FRONT;
      req_push_value = '0;
      item_typed     = 1'b0;
      item_result    = '0;
      burst_left     = 0;
      phase_left     = 0;
      push_percent   = 50;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < PLAN_ROWS; row++)
         send_item(PLAN[row].kind, PLAN[row].word, PLAN[row].typed, PLAN[row].result);

      for (int n = PLAN_ROWS; n < ITEM_COUNT; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 1) == 1) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         burst_left--;
         // Fill, drain and balanced phases walk the ring between empty and full.
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
               0:       push_percent = 80;
               1:       push_percent = 20;
               default: push_percent = 50;
            endcase
         end
         phase_left--;
         if ($urandom_range(0, 99) < push_percent)
            kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
         else
            kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
         case ($urandom_range(0, 19))
            0:       word = 32'h8000_0000;
            1:       word = 32'h7FFF_FFFF;
            2:       word = 32'hFFFF_FFFF;
            3:       word = 32'h0000_0000;
            default: word = $urandom;
         endcase
         send_item(kind, word, 1'b0, '0);
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
